@@ sv/annexb_nal_unit_splitter_top_macros.svh @@
// Assertion macros shared by the splitter modules.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_TOP_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_TOP_MACROS_SVH

`define ANXB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`define ANXB_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) else $error(msg);

`endif

@@ sv/anxb_pkg.sv @@
package anxb_pkg;

    localparam int unsigned LenW = 21;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_LEAD  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [LenW-1:0] LIMIT_LOW   = 21'd4;
    localparam logic [LenW-1:0] LIMIT_HIGH  = 21'd1048576;
    localparam logic [LenW-1:0] LIMIT_RESET = 21'd65536;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_UNIT = 2'd1,
        PH_HALT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]      unit_byte;
        logic            first_of_unit;
        logic            last_of_unit;
        logic [LenW-1:0] unit_length;
        logic [1:0]      status;
        logic            last_of_run;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       count;
        result_t [3:0]    res;
    } group_t;

    function automatic logic is_code3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
        return (a == 8'h00) && (b == 8'h00) && (c == 8'h01);
    endfunction

    function automatic logic is_code4(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
        return (a == 8'h00) && (b == 8'h00) && (c == 8'h00) && (d == 8'h01);
    endfunction

endpackage

@@ sv/anxb_parse.sv @@
`include "annexb_nal_unit_splitter_top_macros.svh"

module anxb_parse (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic [0:0]             s_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [20:0]            cfg_data,
    input  logic                   can_load,
    output anxb_pkg::group_t       grp
);

    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [7:0]           in_byte_reg;
    anxb_pkg::phase_t     phase_reg, phase_next;
    logic [3:0][7:0]      pend_reg, pend_next;
    logic [2:0]           count_reg, count_next;
    logic [20:0]          uc_reg, uc_next;
    logic [20:0]          lim_reg, lim_next;

    logic                 load;
    logic [3:0][7:0]      emit;
    logic [2:0]           emit_n;
    logic                 ends_unit;
    logic                 err;
    logic [1:0]           lead_k;
    logic [1:0]           last_idx;
    logic [3:0][20:0]     len_sum;
    logic [3:0]           over;

    assign load      = in_valid_reg && can_load;
    assign s_tready  = !in_valid_reg || can_load;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data < anxb_pkg::LIMIT_LOW) begin
            lim_next = anxb_pkg::LIMIT_LOW;
        end else if (cfg_data > anxb_pkg::LIMIT_HIGH) begin
            lim_next = anxb_pkg::LIMIT_HIGH;
        end else begin
            lim_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= anxb_pkg::PH_LEAD;
            pend_reg  <= '0;
            count_reg <= 3'd0;
            uc_reg    <= 21'd0;
            lim_reg   <= anxb_pkg::LIMIT_RESET;
        end else begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            uc_reg    <= uc_next;
            if (cfg_valid && cfg_ready) begin
                lim_reg <= lim_next;
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        uc_next    = uc_reg;
        emit       = '0;
        emit_n     = 3'd0;
        ends_unit  = 1'b0;
        err        = 1'b0;
        lead_k     = (count_reg >= 3'd3) ? 2'd3 : count_reg[1:0];

        if (load) begin
            unique case (phase_reg)
                anxb_pkg::PH_LEAD: begin
                    if (in_op_reg == anxb_pkg::OP_EOS) begin
                        pend_next  = '0;
                        count_next = 3'd0;
                    end else begin
                        pend_next[lead_k] = in_byte_reg;
                        count_next        = {1'b0, lead_k} + 3'd1;
                        uc_next           = 21'd0;
                        if (count_next == 3'd3 &&
                            anxb_pkg::is_code3(pend_next[0], pend_next[1], pend_next[2])) begin
                            phase_next = anxb_pkg::PH_UNIT;
                        end else if (count_next == 3'd4) begin
                            if (anxb_pkg::is_code4(pend_next[0], pend_next[1],
                                                   pend_next[2], pend_next[3])) begin
                                phase_next = anxb_pkg::PH_UNIT;
                            end else begin
                                err        = 1'b1;
                                phase_next = anxb_pkg::PH_HALT;
                            end
                        end
                    end
                end
                anxb_pkg::PH_UNIT: begin
                    if (in_op_reg == anxb_pkg::OP_EOS) begin
                        emit       = pend_reg;
                        emit_n     = count_reg;
                        ends_unit  = 1'b1;
                        pend_next  = '0;
                        count_next = 3'd0;
                        phase_next = anxb_pkg::PH_LEAD;
                    end else if (count_reg == 3'd4) begin
                        if (anxb_pkg::is_code4(pend_reg[1], pend_reg[2], pend_reg[3],
                                               in_byte_reg)) begin
                            emit[0]    = pend_reg[0];
                            emit_n     = 3'd1;
                            ends_unit  = 1'b1;
                            pend_next  = {in_byte_reg, pend_reg[3], pend_reg[2], pend_reg[1]};
                            count_next = 3'd4;
                        end else if (anxb_pkg::is_code3(pend_reg[2], pend_reg[3],
                                                        in_byte_reg)) begin
                            emit[0]    = pend_reg[0];
                            emit[1]    = pend_reg[1];
                            emit_n     = 3'd2;
                            ends_unit  = 1'b1;
                            pend_next  = {8'h00, in_byte_reg, pend_reg[3], pend_reg[2]};
                            count_next = 3'd3;
                        end else begin
                            emit[0]    = pend_reg[0];
                            emit_n     = 3'd1;
                            pend_next  = {in_byte_reg, pend_reg[3], pend_reg[2], pend_reg[1]};
                            count_next = 3'd4;
                        end
                    end else begin
                        if (anxb_pkg::is_code4(pend_reg[0], pend_reg[1], pend_reg[2],
                                               in_byte_reg)) begin
                            ends_unit  = 1'b1;
                            pend_next  = {in_byte_reg, pend_reg[2], pend_reg[1], pend_reg[0]};
                            count_next = 3'd4;
                        end else if (anxb_pkg::is_code3(pend_reg[1], pend_reg[2],
                                                        in_byte_reg)) begin
                            emit[0]    = pend_reg[0];
                            emit_n     = 3'd1;
                            ends_unit  = 1'b1;
                            pend_next  = {8'h00, in_byte_reg, pend_reg[2], pend_reg[1]};
                            count_next = 3'd3;
                        end else begin
                            pend_next  = {in_byte_reg, pend_reg[2], pend_reg[1], pend_reg[0]};
                            count_next = 3'd4;
                        end
                    end
                end
                anxb_pkg::PH_HALT: begin
                end
                default: begin
                end
            endcase
        end

        for (int j = 0; j < 4; j++) begin
            len_sum[j] = uc_reg + 21'(j + 1);
            over[j]    = len_sum[j] > lim_reg;
        end

        last_idx = 2'(emit_n - 3'd1);
        if (load && phase_reg == anxb_pkg::PH_UNIT) begin
            if (ends_unit) begin
                uc_next = 21'd0;
            end else if (emit_n != 3'd0) begin
                uc_next = over[last_idx] ? lim_reg + 21'd1 : len_sum[last_idx];
            end
        end
    end

    always_comb begin
        grp.valid = load;
        grp.count = err ? 3'd1 : emit_n;
        for (int j = 0; j < 4; j++) begin
            grp.res[j].unit_byte     = emit[j];
            grp.res[j].first_of_unit = (j == 0) && (uc_reg == 21'd0);
            grp.res[j].last_of_run   = (3'(j + 1) == emit_n);
            grp.res[j].last_of_unit  = ends_unit && (3'(j + 1) == emit_n);
            grp.res[j].unit_length   = grp.res[j].last_of_unit ?
                                       (over[j] ? lim_reg : len_sum[j]) : 21'd0;
            grp.res[j].status        = over[j] ? anxb_pkg::ST_OVERFLOW : anxb_pkg::ST_OK;
        end
        if (err) begin
            grp.res[0]             = '0;
            grp.res[0].status      = anxb_pkg::ST_NO_LEAD;
            grp.res[0].last_of_run = 1'b1;
        end
    end

    `ANXB_ASSERT(a_unit_pending, phase_reg != anxb_pkg::PH_UNIT || count_reg == 3'd3 || count_reg == 3'd4, "Unit phase holds a pending count other than three or four.")
    `ANXB_ASSERT(a_limit_range, lim_reg >= anxb_pkg::LIMIT_LOW && lim_reg <= anxb_pkg::LIMIT_HIGH, "Unit limit lies outside its range.")
    `ANXB_ASSERT_NEXT(a_halt_sticky, phase_reg == anxb_pkg::PH_HALT, phase_reg == anxb_pkg::PH_HALT, "Halted splitter left the halt phase without reset.")

endmodule

@@ sv/anxb_out_queue.sv @@
`include "annexb_nal_unit_splitter_top_macros.svh"

module anxb_out_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  anxb_pkg::group_t       grp,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,
    output logic [3:0]             m_tuser,
    output logic                   m_tlast
);

    anxb_pkg::result_t [3:0] res_reg;
    logic [2:0]              n_reg, n_next;
    logic [2:0]              rd_reg, rd_next;
    logic                    take;
    anxb_pkg::result_t       cur;

    assign m_tvalid = (rd_reg != n_reg);
    assign take     = m_tvalid && m_tready;
    assign can_load = !m_tvalid || (take && (rd_reg + 3'd1 == n_reg));
    assign cur      = res_reg[rd_reg[1:0]];

    assign m_tdata = {3'b000, cur.unit_length, cur.unit_byte};
    assign m_tuser = {cur.status, cur.last_of_unit, cur.first_of_unit};
    assign m_tlast = cur.last_of_run;

    always_comb begin
        n_next  = n_reg;
        rd_next = rd_reg;
        if (grp.valid) begin
            n_next  = grp.count;
            rd_next = 3'd0;
        end else if (take) begin
            rd_next = rd_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg  <= 3'd0;
            rd_reg <= 3'd0;
        end else begin
            n_reg  <= n_next;
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp.valid) begin
            res_reg <= grp.res;
        end
    end

    `ANXB_ASSERT(a_rd_in_range, rd_reg <= n_reg, "Read index passed the number of stored results.")
    `ANXB_ASSERT(a_count_bound, n_reg <= 3'd4, "More than four results stored for one item.")
    `ANXB_ASSERT(a_tlast_final, !m_tvalid || (m_tlast == (rd_reg + 3'd1 == n_reg)), "Run end mark does not sit on the final stored result.")

endmodule

@@ sv/annexb_nal_unit_splitter_top.sv @@
// H.264 Annex B splitter: cuts a byte stream into NAL units at 00 00 01 and
// 00 00 00 01 start codes, each unit given out with its leading start code.
// Input channel s_*: one item per byte (tuser = 0) or an end-of-stream mark
// (tuser = 1) that flushes the unit in progress. Result channel m_*: one item
// per unit byte, with first and last unit marks in tuser, the unit length on
// the last byte, and tlast on the final result that one input item causes.
// The cfg channel writes max_unit_bytes; it is always ready. The user must
// write it only while the block is idle; the block does not enforce this.
// Items pass the input register, then the result store. A byte item gives at
// most two results and usually one, so one byte per cycle is sustained with
// m_tready high; an end-of-stream item gives up to four results. The rate is
// set by the four-entry result store, which gives one result per cycle with
// m_tready high and takes the next item's results as its last one leaves.
// Reset clears the held bytes and counters, sets the limit to 65536 and makes
// the block wait for a leading start code. If the first four bytes hold none,
// the block gives a single error result and ignores input until reset.
// While m_tready is low the current result holds, one further item waits in
// the input register and s_tready then falls.
module annexb_nal_unit_splitter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] unit_byte, [28:8] unit_length, [31:29] zero
    output logic [3:0]  m_tuser,   // [0] first_of_unit, [1] last_of_unit, [3:2] status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data
);

    anxb_pkg::group_t grp;
    logic             can_load;

    anxb_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .can_load  (can_load),
        .grp       (grp)
    );

    anxb_out_queue u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .grp      (grp),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/tb_annexb_nal_unit_splitter_top.sv @@
`timescale 1ns / 100ps

module tb_annexb_nal_unit_splitter_top;

    typedef enum logic {
        ROW_ITEM,
        ROW_LIMIT
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               op;
        logic [20:0]        value;
        logic               typed;
        anxb_pkg::result_t  want;
    } row_t;

    localparam int N_ROWS   = 29;
    localparam int TAIL_ROW = 23;

    // Rows from TAIL_ROW on leave the block halted, so they run after the random part.
    localparam row_t DIR_ROWS [N_ROWS] = '{
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h01, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'hAA, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'hBB, 1'b1,
          '{8'h00, 1'b1, 1'b0, 21'd0, anxb_pkg::ST_OK, 1'b1}},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h01, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h01, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_EOS,  21'hFF, 1'b0, '0},
        '{ROW_LIMIT, anxb_pkg::OP_DATA, anxb_pkg::LIMIT_LOW, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_EOS,  21'h5A, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h01, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h11, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h22, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_EOS,  21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_EOS,  21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h00, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h02, 1'b0, '0},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h05, 1'b1,
          '{8'h00, 1'b0, 1'b0, 21'd0, anxb_pkg::ST_NO_LEAD, 1'b1}},
        '{ROW_ITEM,  anxb_pkg::OP_DATA, 21'h01, 1'b0, '0}
    };

    localparam logic [20:0] SEG_LIMITS [8] = '{
        21'd0, 21'd9, anxb_pkg::LIMIT_HIGH, 21'h1FFFFF, 21'd5, 21'd20,
        anxb_pkg::LIMIT_RESET, 21'd1
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_tuser = 1'b0;    // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] unit_byte, [28:8] unit_length, [31:29] zero
    logic [3:0]  m_tuser;           // [0] first_of_unit, [1] last_of_unit, [3:2] status
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [20:0] cfg_data = 21'd0;

    logic [20:0]        limit_reg = anxb_pkg::LIMIT_RESET;
    anxb_pkg::phase_t   ph = anxb_pkg::PH_LEAD;
    logic [7:0]         held [4] = '{default: 8'h00};
    logic [2:0]         held_cnt = 3'd0;
    logic [20:0]        unit_cnt = 21'd0;
    anxb_pkg::result_t  run_out [$];
    anxb_pkg::result_t  unit_bytes_due [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int items_sent = 0;

    annexb_nal_unit_splitter_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [20:0] cur_limit();
        if (limit_reg < anxb_pkg::LIMIT_LOW) return anxb_pkg::LIMIT_LOW;
        if (limit_reg > anxb_pkg::LIMIT_HIGH) return anxb_pkg::LIMIT_HIGH;
        return limit_reg;
    endfunction

    function automatic bit code_at(input logic [7:0] w [5], input int p, input int len);
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < len; i++) begin
            if (w[p + i] != ((i == len - 1) ? 8'h01 : 8'h00)) ok = 1'b0;
        end
        return ok;
    endfunction

    task automatic emit_unit_byte(input logic [7:0] b, input bit is_last);
        logic [20:0]        lim;
        logic               over;
        anxb_pkg::result_t  r;
        lim = cur_limit();
        r = '0;
        r.unit_byte = b;
        r.first_of_unit = (unit_cnt == 21'd0);
        if (unit_cnt <= lim) unit_cnt = unit_cnt + 21'd1;
        over = (unit_cnt > lim);
        r.last_of_unit = is_last;
        if (is_last) r.unit_length = over ? lim : unit_cnt;
        r.status = over ? anxb_pkg::ST_OVERFLOW : anxb_pkg::ST_OK;
        run_out.push_back(r);
        if (is_last) unit_cnt = 21'd0;
    endtask

    task automatic split_step(input logic op, input logic [7:0] b);
        logic [7:0]         w [5];
        int                 k;
        int                 cnt;
        int                 sc;
        int                 m;
        anxb_pkg::result_t  r;
        run_out.delete();
        k = held_cnt;
        if (k > 4) k = 4;
        for (int i = 0; i < 5; i++) w[i] = 8'h00;
        for (int i = 0; i < k; i++) w[i] = held[i];
        unique case (ph)
            anxb_pkg::PH_LEAD: begin
                if (op == anxb_pkg::OP_EOS) begin
                    held_cnt = 3'd0;
                    foreach (held[i]) held[i] = 8'h00;
                end else begin
                    if (k >= 4) k = 3;
                    held[k] = b;
                    held_cnt = 3'(k + 1);
                    unit_cnt = 21'd0;
                    for (int i = 0; i < 4; i++) w[i] = held[i];
                    if (held_cnt == 3'd3 && code_at(w, 0, 3)) begin
                        ph = anxb_pkg::PH_UNIT;
                    end else if (held_cnt == 3'd4) begin
                        if (code_at(w, 0, 4)) begin
                            ph = anxb_pkg::PH_UNIT;
                        end else begin
                            r = '0;
                            r.status = anxb_pkg::ST_NO_LEAD;
                            run_out.push_back(r);
                            ph = anxb_pkg::PH_HALT;
                        end
                    end
                end
            end
            anxb_pkg::PH_UNIT: begin
                if (op == anxb_pkg::OP_EOS) begin
                    for (int i = 0; i < k; i++) emit_unit_byte(held[i], i + 1 == k);
                    foreach (held[i]) held[i] = 8'h00;
                    held_cnt = 3'd0;
                    unit_cnt = 21'd0;
                    ph = anxb_pkg::PH_LEAD;
                end else begin
                    w[k] = b;
                    cnt = k + 1;
                    sc = 0;
                    if (cnt >= 4 && code_at(w, cnt - 4, 4)) sc = 4;
                    else if (cnt >= 3 && code_at(w, cnt - 3, 3)) sc = 3;
                    if (sc != 0) begin
                        m = cnt - sc;
                        for (int i = 0; i < m; i++) emit_unit_byte(w[i], i + 1 == m);
                        unit_cnt = 21'd0;
                        for (int i = 0; i < 4; i++) begin
                            if (i < sc) held[i] = w[m + i];
                            else held[i] = 8'h00;
                        end
                        held_cnt = 3'(sc);
                    end else if (cnt == 5) begin
                        emit_unit_byte(w[0], 1'b0);
                        for (int i = 0; i < 4; i++) held[i] = w[i + 1];
                        held_cnt = 3'd4;
                    end else begin
                        for (int i = 0; i < cnt; i++) held[i] = w[i];
                        held_cnt = 3'(cnt);
                    end
                end
            end
            default: begin
            end
        endcase
        if (run_out.size() > 0) begin
            r = run_out.pop_back();
            r.last_of_run = 1'b1;
            run_out.push_back(r);
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] b, input logic typed,
                             input anxb_pkg::result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        split_step(op, b);
        if (typed) unit_bytes_due.push_back(want);
        else while (run_out.size() > 0) unit_bytes_due.push_back(run_out.pop_front());
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(anxb_pkg::OP_DATA, b, 1'b0, '0);
    endtask

    task automatic send_eos();
        send_item(anxb_pkg::OP_EOS, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    task automatic send_start_code(input int len, input int upto);
        for (int i = 0; i < upto; i++) send_byte((i == len - 1) ? 8'h01 : 8'h00);
    endtask

    function automatic logic [7:0] rand_body_byte();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 8'h00;
        if (r < 50) return 8'h01;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_stream();
        int len;
        int nunits;
        int body;
        len = $urandom_range(3, 4);
        if ($urandom_range(7) == 0) begin
            send_start_code(len, $urandom_range(0, len - 1));
            send_eos();
        end else begin
            send_start_code(len, len);
            nunits = $urandom_range(1, 3);
            for (int u = 0; u < nunits; u++) begin
                body = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 10);
                for (int i = 0; i < body; i++) send_byte(rand_body_byte());
                if (u + 1 < nunits) begin
                    len = $urandom_range(3, 4);
                    send_start_code(len, len);
                end
            end
            send_eos();
        end
    endtask

    task automatic write_limit(input logic [20:0] v);
        s_tvalid <= 1'b0;
        while (unit_bytes_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        limit_reg = v;
    endtask

    task automatic walk_rows(input int lo, input int hi);
        for (int i = lo; i < hi; i++) begin
            if (DIR_ROWS[i].kind == ROW_LIMIT) begin
                write_limit(DIR_ROWS[i].value);
            end else begin
                send_item(DIR_ROWS[i].op, DIR_ROWS[i].value[7:0], DIR_ROWS[i].typed,
                          DIR_ROWS[i].want);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [20:0] exp_v,
                               input logic [20:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    initial begin
        anxb_pkg::result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (unit_bytes_due.size() == 0) begin
                    $error("unexpected item: unit_byte %0h", m_tdata[7:0]);
                    mismatches++;
                end else begin
                    want = unit_bytes_due.pop_front();
                    check_field("unit_byte", 21'(want.unit_byte), 21'(m_tdata[7:0]));
                    check_field("first_of_unit", 21'(want.first_of_unit), 21'(m_tuser[0]));
                    check_field("last_of_unit", 21'(want.last_of_unit), 21'(m_tuser[1]));
                    check_field("unit_length", want.unit_length, m_tdata[28:8]);
                    check_field("status", 21'(want.status), 21'(m_tuser[3:2]));
                    check_field("last_of_run", 21'(want.last_of_run), 21'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int target;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        walk_rows(0, TAIL_ROW);
        for (int seg = 0; seg < 8; seg++) begin
            write_limit(SEG_LIMITS[seg]);
            case (seg % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 71;
                end
                default: begin
                    send_idle_pct = 10;
                    recv_stall_pct = 10;
                end
            endcase
            target = items_sent + 16;
            while (items_sent < target) send_stream();
        end
        walk_rows(TAIL_ROW, N_ROWS);
        s_tvalid <= 1'b0;
        while (unit_bytes_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/anxb_pkg.sv
sv/anxb_parse.sv
sv/anxb_out_queue.sv
sv/annexb_nal_unit_splitter_top.sv
tb/tb_annexb_nal_unit_splitter_top.sv
